### rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: property violated");

// boolean condition must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("%m: forbidden condition seen");

`endif

### rtl/core/yrmb_pkg.sv
package yrmb_pkg;

    localparam int MAX_MCU_COLUMNS = 64;
    localparam int MAX_STRIPS      = 1024;

    localparam int LINE_WORDS  = MAX_MCU_COLUMNS * 8;
    localparam int WORD_W      = $clog2(LINE_WORDS);
    localparam int MCU_W       = (MAX_MCU_COLUMNS > 1) ? $clog2(MAX_MCU_COLUMNS) : 1;
    localparam int STRIP_W     = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1;
    localparam int ADDR_W      = 1 + 3 + WORD_W;
    localparam int STORE_DEPTH = 2 ** ADDR_W;
    localparam int COL_EFF_W   = $clog2(MAX_MCU_COLUMNS + 1);
    localparam int STRIP_EFF_W = $clog2(MAX_STRIPS + 1);

    localparam int CFG_COL_W   = 7;
    localparam int CFG_STRIP_W = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 1;

    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [7:0] LEVEL_SHIFT = 8'h80;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MCU_COLUMNS = 1'b0,
        CFG_STRIP_COUNT = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        COMP_LUMA_LEFT  = 2'd0,
        COMP_LUMA_RIGHT = 2'd1,
        COMP_CB         = 2'd2,
        COMP_CR         = 2'd3
    } t_comp;

    typedef enum logic [1:0] {
        LANE_Y0 = 2'd0,
        LANE_CB = 2'd1,
        LANE_Y1 = 2'd2,
        LANE_CR = 2'd3
    } t_lane;

    typedef struct packed {
        logic              rd;
        logic [ADDR_W-1:0] rd_addr;
        t_lane             lane;
        t_comp             component;
        logic              block_end;
        logic              image_end;
        logic              run_end;
        logic              wr;
        logic [ADDR_W-1:0] wr_addr;
        logic [31:0]       wr_data;
    } t_cmd;

    typedef struct packed {
        logic [7:0] sample;
        t_comp      component;
        logic       block_end;
        logic       image_end;
        logic       run_end;
    } t_res;

endpackage

### rtl/core/yrmb_front.sv
`include "assert_macros.svh"

module yrmb_front
    import yrmb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_func,
    input  logic [31:0]           i_word,
    input  logic                  i_cq_full,
    output logic                  o_cmd_push,
    output t_cmd                  o_cmd
);

    logic [CFG_COL_W-1:0]   r_mcu_columns;
    logic [CFG_STRIP_W-1:0] r_strip_count;

    logic        r_busy, n_busy;
    logic [1:0]  r_cnt, n_cnt;
    logic        r_func;
    logic [31:0] r_word;

    logic               r_write_bank, n_write_bank;
    logic [WORD_W-1:0]  r_write_word, n_write_word;
    logic [2:0]         r_write_line, n_write_line;
    logic [STRIP_W-1:0] r_strips_written, n_strips_written;
    logic               r_pending, n_pending;
    logic [MCU_W-1:0]   r_read_mcu, n_read_mcu;
    t_comp              r_read_block, n_read_block;
    logic [5:0]         r_read_index, n_read_index;
    logic [STRIP_W-1:0] r_strips_emitted, n_strips_emitted;

    logic [COL_EFF_W-1:0]   eff_cols;
    logic [STRIP_EFF_W-1:0] eff_strips;
    logic [2:0]             row, col;
    logic [WORD_W-1:0]      rd_off, rd_word;
    t_lane                  rd_lane;
    logic blk_end, last_mcu, strip_end, img_end;
    logic do_read, finish, step, accept, do_write;

    // effective limits
    always_comb begin
        if (r_mcu_columns == '0) begin
            eff_cols = COL_EFF_W'(1);
        end else if (32'(r_mcu_columns) > MAX_MCU_COLUMNS) begin
            eff_cols = COL_EFF_W'(MAX_MCU_COLUMNS);
        end else begin
            eff_cols = COL_EFF_W'(r_mcu_columns);
        end
        if (r_strip_count == '0) begin
            eff_strips = STRIP_EFF_W'(1);
        end else if (32'(r_strip_count) > MAX_STRIPS) begin
            eff_strips = STRIP_EFF_W'(MAX_STRIPS);
        end else begin
            eff_strips = STRIP_EFF_W'(r_strip_count);
        end
    end

    // read address of the next sample
    always_comb begin
        row = r_read_index[5:3];
        col = r_read_index[2:0];
        case (r_read_block)
            COMP_LUMA_LEFT: begin
                rd_off  = WORD_W'(col[2:1]);
                rd_lane = col[0] ? LANE_Y1 : LANE_Y0;
            end
            COMP_LUMA_RIGHT: begin
                rd_off  = WORD_W'({1'b1, col[2:1]});
                rd_lane = col[0] ? LANE_Y1 : LANE_Y0;
            end
            COMP_CB: begin
                rd_off  = WORD_W'(col);
                rd_lane = LANE_CB;
            end
            default: begin
                rd_off  = WORD_W'(col);
                rd_lane = LANE_CR;
            end
        endcase
        rd_word = WORD_W'({r_read_mcu, 3'b000}) + rd_off;
    end

    assign blk_end   = &r_read_index;
    assign last_mcu  = (32'(r_read_mcu) + 32'd1) >= 32'(eff_cols);
    assign strip_end = blk_end && (r_read_block == COMP_CR) && last_mcu;
    assign img_end   = strip_end && ((32'(r_strips_emitted) + 32'd1) >= 32'(eff_strips));

    assign do_read  = r_pending;
    assign finish   = !do_read || (r_cnt == 2'd3) || strip_end;
    assign step     = r_busy && !i_cq_full;
    assign do_write = step && finish && !r_func;
    assign full     = r_busy && !(step && finish);
    assign accept   = push && !full;

    // command to the back end
    always_comb begin
        o_cmd_push       = step && (do_read || do_write);
        o_cmd.rd         = step && do_read;
        o_cmd.rd_addr    = {~r_write_bank, row, rd_word};
        o_cmd.lane       = rd_lane;
        o_cmd.component  = r_read_block;
        o_cmd.block_end  = blk_end;
        o_cmd.image_end  = img_end;
        o_cmd.run_end    = do_read && finish;
        o_cmd.wr         = do_write;
        o_cmd.wr_addr    = {r_write_bank, r_write_line, r_write_word};
        o_cmd.wr_data    = r_word;
    end

    // sequencing of reads then the write
    always_comb begin
        n_busy           = r_busy;
        n_cnt            = r_cnt;
        n_write_bank     = r_write_bank;
        n_write_word     = r_write_word;
        n_write_line     = r_write_line;
        n_strips_written = r_strips_written;
        n_pending        = r_pending;
        n_read_mcu       = r_read_mcu;
        n_read_block     = r_read_block;
        n_read_index     = r_read_index;
        n_strips_emitted = r_strips_emitted;

        if (step) begin
            n_cnt = finish ? 2'd0 : r_cnt + 2'd1;
            if (do_read) begin
                if (!blk_end) begin
                    n_read_index = r_read_index + 6'd1;
                end else begin
                    n_read_index = '0;
                    if (r_read_block != COMP_CR) begin
                        n_read_block = t_comp'(r_read_block + 2'd1);
                    end else begin
                        n_read_block = COMP_LUMA_LEFT;
                        if (!last_mcu) begin
                            n_read_mcu = r_read_mcu + 1'b1;
                        end else begin
                            n_read_mcu       = '0;
                            n_pending        = 1'b0;
                            n_strips_emitted = img_end ? '0 : r_strips_emitted + 1'b1;
                        end
                    end
                end
            end
            if (finish) begin
                n_busy = 1'b0;
            end
            if (do_write) begin
                if ((32'(r_write_word) + 32'd1) < (32'(eff_cols) * 32'd8)) begin
                    n_write_word = r_write_word + 1'b1;
                end else begin
                    n_write_word = '0;
                    if (r_write_line != 3'd7) begin
                        n_write_line = r_write_line + 3'd1;
                    end else begin
                        n_write_line = '0;
                        if ((32'(r_strips_written) + 32'd1) >= 32'(eff_strips)) begin
                            n_strips_written = '0;
                        end else begin
                            n_strips_written = r_strips_written + 1'b1;
                        end
                        n_write_bank = ~r_write_bank;
                        n_pending    = 1'b1;
                        n_read_mcu   = '0;
                        n_read_block = COMP_LUMA_LEFT;
                        n_read_index = '0;
                    end
                end
            end
        end
        if (accept) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcu_columns    <= CFG_COL_W'(1);
            r_strip_count    <= CFG_STRIP_W'(1);
            r_busy           <= 1'b0;
            r_cnt            <= '0;
            r_write_bank     <= 1'b0;
            r_write_word     <= '0;
            r_write_line     <= '0;
            r_strips_written <= '0;
            r_pending        <= 1'b0;
            r_read_mcu       <= '0;
            r_read_block     <= COMP_LUMA_LEFT;
            r_read_index     <= '0;
            r_strips_emitted <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_MCU_COLUMNS: r_mcu_columns <= i_cfg_data[CFG_COL_W-1:0];
                    CFG_STRIP_COUNT: r_strip_count <= i_cfg_data[CFG_STRIP_W-1:0];
                    default: ;
                endcase
            end
            r_busy           <= n_busy;
            r_cnt            <= n_cnt;
            r_write_bank     <= n_write_bank;
            r_write_word     <= n_write_word;
            r_write_line     <= n_write_line;
            r_strips_written <= n_strips_written;
            r_pending        <= n_pending;
            r_read_mcu       <= n_read_mcu;
            r_read_block     <= n_read_block;
            r_read_index     <= n_read_index;
            r_strips_emitted <= n_strips_emitted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_word <= i_word;
        end
    end

    `ASSERT_ALWAYS(a_pending_from_write, i_clk, i_rst_n, $rose(r_pending) |-> $past(o_cmd_push && o_cmd.wr))
    `ASSERT_ALWAYS(a_run_end_with_read, i_clk, i_rst_n, (o_cmd_push && o_cmd.run_end) |-> o_cmd.rd)
    `ASSERT_NEVER(a_idle_count_clear, i_clk, i_rst_n, !r_busy && (r_cnt != 2'd0))

endmodule

### rtl/core/yrmb_cmd_fifo.sv
module yrmb_cmd_fifo
    import yrmb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd                r_slot [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wptr, r_rptr;
    logic [CQ_CNT_W-1:0] r_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == CQ_CNT_W'(CQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/yrmb_back.sv
`include "assert_macros.svh"

module yrmb_back
    import yrmb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_empty,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic empty,
    input  logic pop,
    output t_res o_res
);

    logic [31:0] r_store [STORE_DEPTH];
    logic [31:0] r_rd_data;
    t_lane       r_lane;
    t_comp       r_comp;
    logic        r_blk_end, r_img_end, r_run_end;
    logic        r_inflight;

    t_res                r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wptr, r_rptr;
    logic [OQ_CNT_W-1:0] r_count;

    logic [7:0] byte_sel;
    t_res       res_in;
    logic       out_pop, has_room;

    // a read may only go out when its result has a slot
    assign has_room  = (32'(r_count) + 32'(r_inflight)) < OQ_DEPTH;
    assign o_cmd_pop = !i_cmd_empty && (!i_cmd.rd || has_room);
    assign out_pop   = pop && !empty;
    assign empty     = (r_count == '0);
    assign o_res     = r_oq[r_rptr];

    always_comb begin
        byte_sel         = r_rd_data[{r_lane, 3'b000} +: 8];
        res_in.sample    = byte_sel ^ LEVEL_SHIFT;
        res_in.component = r_comp;
        res_in.block_end = r_blk_end;
        res_in.image_end = r_img_end;
        res_in.run_end   = r_run_end;
    end

    // strip memory
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.wr) begin
            r_store[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (o_cmd_pop && i_cmd.rd) begin
            r_rd_data <= r_store[i_cmd.rd_addr];
            r_lane    <= i_cmd.lane;
            r_comp    <= i_cmd.component;
            r_blk_end <= i_cmd.block_end;
            r_img_end <= i_cmd.image_end;
            r_run_end <= i_cmd.run_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 1'b0;
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_count    <= '0;
        end else begin
            r_inflight <= o_cmd_pop && i_cmd.rd;
            if (r_inflight) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (out_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (r_inflight && !out_pop) begin
                r_count <= r_count + 1'b1;
            end else if (out_pop && !r_inflight) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_inflight) begin
            r_oq[r_wptr] <= res_in;
        end
    end

    `ASSERT_NEVER(a_oq_overflow, i_clk, i_rst_n, (r_count == OQ_CNT_W'(OQ_DEPTH)) && r_inflight && !out_pop)
    `ASSERT_ALWAYS(a_inflight_from_read, i_clk, i_rst_n, r_inflight |-> $past(o_cmd_pop && i_cmd.rd))
    `ASSERT_ALWAYS(a_image_end_closes, i_clk, i_rst_n, (!empty && o_res.image_end) |-> (o_res.block_end && o_res.run_end))

endmodule

### rtl/core/yuyv_raster_to_mcu_blocks_unit.sv
// YUYV 4:2:2 raster words in, level-shifted 8x8 blocks out as 16x8 MCUs (left luma,
// right luma, Cb, Cr). Pixel words fill 8-line strips in a two-bank 8192 x 32 strip
// memory; while one strip fills, the previous one drains, up to four samples per
// accepted word, and a new word is taken only once those samples are issued. The
// single read port of the strip memory yields one sample a cycle unless the command
// queue is full. A flush word stores nothing and only drains. The memory is not
// cleared after reset and needs no start-up pass. Write the registers only while the
// block is idle.
module yuyv_raster_to_mcu_blocks_unit
    import yrmb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_func,
    input  logic [7:0]            i_luma_first,
    input  logic [7:0]            i_chroma_blue,
    input  logic [7:0]            i_luma_second,
    input  logic [7:0]            i_chroma_red,
    output logic                  empty,
    input  logic                  pop,
    output logic signed [7:0]     o_sample,
    output logic [1:0]            o_component,
    output logic                  o_block_end,
    output logic                  o_image_end,
    output logic                  o_run_end
);

    logic cq_push, cq_full, cq_pop, cq_empty;
    t_cmd cq_in, cq_out;
    t_res res;

    yrmb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_func      (i_func),
        .i_word      ({i_chroma_red, i_luma_second, i_chroma_blue, i_luma_first}),
        .i_cq_full   (cq_full),
        .o_cmd_push  (cq_push),
        .o_cmd       (cq_in)
    );

    yrmb_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cq_push),
        .i_cmd   (cq_in),
        .o_full  (cq_full),
        .i_pop   (cq_pop),
        .o_empty (cq_empty),
        .o_cmd   (cq_out)
    );

    yrmb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cq_empty),
        .i_cmd       (cq_out),
        .o_cmd_pop   (cq_pop),
        .empty       (empty),
        .pop         (pop),
        .o_res       (res)
    );

    assign o_sample    = $signed(res.sample);
    assign o_component = res.component;
    assign o_block_end = res.block_end;
    assign o_image_end = res.image_end;
    assign o_run_end   = res.run_end;

endmodule

### dv/yuyv_mcu_tb_pkg.sv
`timescale 1ns / 1ps
package yuyv_mcu_tb_pkg;

    typedef enum logic {
        FUNC_PIXEL = 1'b0,
        FUNC_FLUSH = 1'b1
    } t_word_kind;

endpackage

### dv/mcu_block_checker.sv
`timescale 1ns / 1ps
module mcu_block_checker
    import yrmb_pkg::*;
    import yuyv_mcu_tb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    input  logic                  i_full,
    input  logic                  i_func,
    input  logic [7:0]            i_luma_first,
    input  logic [7:0]            i_chroma_blue,
    input  logic [7:0]            i_luma_second,
    input  logic [7:0]            i_chroma_red,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  logic signed [7:0]     i_sample,
    input  logic [1:0]            i_component,
    input  logic                  i_block_end,
    input  logic                  i_image_end,
    input  logic                  i_run_end,
    output int                    o_fail_count,
    output int                    o_due_count
);

    logic [CFG_COL_W-1:0]   cols_reg;
    logic [CFG_STRIP_W-1:0] strips_reg;
    bit   [31:0]            strip_mem [STORE_DEPTH];
    logic                   fill_bank;
    int                     fill_word;
    int                     fill_line;
    logic                   strip_pending;
    int                     rd_mcu;
    t_comp                  rd_block;
    int                     rd_index;
    int                     strips_sent;
    t_res                   mcu_samples_due [$];
    int                     fail_count;

    // emit up to four samples of the pending strip, then store the word if it is a pixel word
    task automatic drain_and_store(input t_word_kind kind, input logic [31:0] pix);
        int         cols;
        int         strips;
        int         row;
        int         col;
        int         word_idx;
        int         n;
        t_lane      lane;
        logic [7:0] stored;
        logic       blk_last;
        logic       mcu_last;
        t_res       burst [4];
        cols   = (cols_reg == 0) ? 1 :
                 ((cols_reg > MAX_MCU_COLUMNS) ? MAX_MCU_COLUMNS : int'(cols_reg));
        strips = (strips_reg == 0) ? 1 :
                 ((strips_reg > MAX_STRIPS) ? MAX_STRIPS : int'(strips_reg));
        n = 0;
        while (n < 4 && strip_pending) begin
            row = rd_index / 8;
            col = rd_index % 8;
            case (rd_block)
                COMP_LUMA_LEFT: begin
                    word_idx = rd_mcu * 8 + col / 2;
                    lane     = (col % 2) ? LANE_Y1 : LANE_Y0;
                end
                COMP_LUMA_RIGHT: begin
                    word_idx = rd_mcu * 8 + 4 + col / 2;
                    lane     = (col % 2) ? LANE_Y1 : LANE_Y0;
                end
                COMP_CB: begin
                    word_idx = rd_mcu * 8 + col;
                    lane     = LANE_CB;
                end
                default: begin
                    word_idx = rd_mcu * 8 + col;
                    lane     = LANE_CR;
                end
            endcase
            stored   = strip_mem[(int'(!fill_bank) * 8 + row) * LINE_WORDS + word_idx]
                                [8 * int'(lane) +: 8];
            blk_last = (rd_index == 63);
            mcu_last = (rd_mcu + 1 >= cols);
            burst[n].sample    = stored ^ LEVEL_SHIFT;
            burst[n].component = rd_block;
            burst[n].block_end = blk_last;
            burst[n].image_end = blk_last && rd_block == COMP_CR && mcu_last &&
                                 (strips_sent + 1 >= strips);
            burst[n].run_end   = 1'b0;
            n++;
            if (!blk_last) begin
                rd_index++;
            end else begin
                rd_index = 0;
                if (rd_block != COMP_CR) begin
                    rd_block = t_comp'(rd_block + 2'd1);
                end else begin
                    rd_block = COMP_LUMA_LEFT;
                    if (!mcu_last) begin
                        rd_mcu++;
                    end else begin
                        rd_mcu        = 0;
                        strip_pending = 1'b0;
                        strips_sent   = burst[n-1].image_end ? 0 : strips_sent + 1;
                    end
                end
            end
        end
        if (n > 0)
            burst[n-1].run_end = 1'b1;
        for (int k = 0; k < n; k++)
            mcu_samples_due.push_back(burst[k]);

        if (kind == FUNC_PIXEL) begin
            strip_mem[(int'(fill_bank) * 8 + fill_line) * LINE_WORDS + fill_word] = pix;
            if (fill_word + 1 < cols * 8) begin
                fill_word++;
            end else begin
                fill_word = 0;
                if (fill_line < 7) begin
                    fill_line++;
                end else begin
                    fill_line     = 0;
                    fill_bank     = !fill_bank;
                    strip_pending = 1'b1;
                    rd_mcu        = 0;
                    rd_block      = COMP_LUMA_LEFT;
                    rd_index      = 0;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_res seen;
        t_res want;
        if (!i_rst_n) begin
            cols_reg      = 1;
            strips_reg    = 1;
            fill_bank     = 1'b0;
            fill_word     = 0;
            fill_line     = 0;
            strip_pending = 1'b0;
            rd_mcu        = 0;
            rd_block      = COMP_LUMA_LEFT;
            rd_index      = 0;
            strips_sent   = 0;
            mcu_samples_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                seen.sample    = i_sample;
                seen.component = t_comp'(i_component);
                seen.block_end = i_block_end;
                seen.image_end = i_image_end;
                seen.run_end   = i_run_end;
                if (mcu_samples_due.size() == 0) begin
                    $display("%0t: sample %0d component %0d arrived with nothing expected",
                             $time, $signed(seen.sample), seen.component);
                    fail_count++;
                end else begin
                    want = mcu_samples_due.pop_front();
                    if (seen !== want) begin
                        $display({"%0t: sample/component/block_end/image_end/run_end",
                                  " expected %0d/%0d/%b/%b/%b got %0d/%0d/%b/%b/%b"},
                                 $time, $signed(want.sample), want.component,
                                 want.block_end, want.image_end, want.run_end,
                                 $signed(seen.sample), seen.component,
                                 seen.block_end, seen.image_end, seen.run_end);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_MCU_COLUMNS: cols_reg   = i_cfg_data[CFG_COL_W-1:0];
                    CFG_STRIP_COUNT: strips_reg = i_cfg_data[CFG_STRIP_W-1:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full)
                drain_and_store(t_word_kind'(i_func),
                                {i_chroma_red, i_luma_second, i_chroma_blue, i_luma_first});
        end
        o_due_count  <= mcu_samples_due.size();
        o_fail_count <= fail_count;
    end

endmodule

### dv/yuyv_raster_to_mcu_blocks_unit_tb.sv
`timescale 1ns / 1ps
module yuyv_raster_to_mcu_blocks_unit_tb;
    import yrmb_pkg::*;
    import yuyv_mcu_tb_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 500;
    localparam int HOLD_AFTER    = 300;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  push;
    logic                  full;
    logic                  i_func;
    logic [7:0]            i_luma_first;
    logic [7:0]            i_chroma_blue;
    logic [7:0]            i_luma_second;
    logic [7:0]            i_chroma_red;
    logic                  empty;
    logic                  pop;
    logic signed [7:0]     o_sample;
    logic [1:0]            o_component;
    logic                  o_block_end;
    logic                  o_image_end;
    logic                  o_run_end;

    int fail_count;
    int due_count;
    int send_idle_pct;
    int take_idle_pct;
    int strip_words;
    int stall_cycles;

    logic [7:0] corner_vals [8] = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h01, 8'hfe, 8'h55, 8'haa};

    yuyv_raster_to_mcu_blocks_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_func        (i_func),
        .i_luma_first  (i_luma_first),
        .i_chroma_blue (i_chroma_blue),
        .i_luma_second (i_luma_second),
        .i_chroma_red  (i_chroma_red),
        .empty         (empty),
        .pop           (pop),
        .o_sample      (o_sample),
        .o_component   (o_component),
        .o_block_end   (o_block_end),
        .o_image_end   (o_image_end),
        .o_run_end     (o_run_end)
    );

    mcu_block_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_full        (full),
        .i_func        (i_func),
        .i_luma_first  (i_luma_first),
        .i_chroma_blue (i_chroma_blue),
        .i_luma_second (i_luma_second),
        .i_chroma_red  (i_chroma_red),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_sample      (o_sample),
        .i_component   (o_component),
        .i_block_end   (o_block_end),
        .i_image_end   (o_image_end),
        .i_run_end     (o_run_end),
        .o_fail_count  (fail_count),
        .o_due_count   (due_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result side, with one long hold-off to back the block up
    initial begin : receiver
        int taken;
        int hold_left;
        bit held;
        taken     = 0;
        hold_left = 0;
        held      = 1'b0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty)
                taken++;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (!held && taken >= HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= take_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_word(input t_word_kind kind, input logic [31:0] pix);
        if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        push          <= 1'b1;
        i_func        <= kind;
        i_luma_first  <= pix[7:0];
        i_chroma_blue <= pix[15:8];
        i_luma_second <= pix[23:16];
        i_chroma_red  <= pix[31:24];
        do @(posedge i_clk); while (full);
    endtask

    task automatic send_pixels(input int count, input int flush_pct);
        repeat (count) begin
            while ($urandom_range(99) < flush_pct)
                send_word(FUNC_FLUSH, $urandom);
            send_word(FUNC_PIXEL, $urandom);
        end
    endtask

    // enough flush words to empty any pending strip
    task automatic drain_strip();
        repeat (strip_words + 2)
            send_word(FUNC_FLUSH, $urandom);
    endtask

    task automatic settle();
        push <= 1'b0;
        do @(posedge i_clk); while (due_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_geometry(input logic [CFG_DATA_W-1:0] cols_data,
                                  input logic [CFG_DATA_W-1:0] strips_data);
        int cols;
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MCU_COLUMNS;
        i_cfg_data  <= cols_data;
        @(posedge i_clk);
        i_cfg_index <= CFG_STRIP_COUNT;
        i_cfg_data  <= strips_data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cols = int'(cols_data[CFG_COL_W-1:0]);
        if (cols == 0)
            cols = 1;
        else if (cols > MAX_MCU_COLUMNS)
            cols = MAX_MCU_COLUMNS;
        strip_words = cols * 64;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_MCU_COLUMNS;
        i_cfg_data    <= '0;
        push          <= 1'b0;
        i_func        <= FUNC_FLUSH;
        i_luma_first  <= '0;
        i_chroma_blue <= '0;
        i_luma_second <= '0;
        i_chroma_red  <= '0;
        send_idle_pct = 33;
        take_idle_pct = 76;
        strip_words   = 64;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner values, flush with nothing pending, then a second image
        write_geometry(CFG_DATA_W'(0), CFG_DATA_W'(0));
        send_word(FUNC_FLUSH, 32'hffff_ffff);
        send_word(FUNC_FLUSH, 32'h0000_0000);
        for (int k = 0; k < 64; k++)
            send_word(FUNC_PIXEL, {corner_vals[(k / 8) % 8], corner_vals[(k + 5) % 8],
                                   corner_vals[(k + 3) % 8], corner_vals[k % 8]});
        send_pixels(strip_words, 15);
        drain_strip();

        // oversized width, then a narrower width
        send_idle_pct = 76;
        take_idle_pct = 33;
        write_geometry({4'($urandom_range(15)), 7'd127}, CFG_DATA_W'(2047));
        send_pixels(20, 0);
        write_geometry(CFG_DATA_W'(2), CFG_DATA_W'(3));
        send_pixels(112, 0);

        // width shrinks while a strip is still draining
        send_idle_pct = 0;
        take_idle_pct = 0;
        send_pixels(64, 0);
        write_geometry(CFG_DATA_W'(1), CFG_DATA_W'(3));
        send_pixels(32, 0);
        drain_strip();

        settle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
